/* design/irc_tok_pkg.sv */
package irc_tok_pkg;

    localparam int DEF_MAX_PARAMS = 15;

    localparam int BYTE_W = 8;
    localparam int KIND_W = 3;
    localparam int IDX_W  = 4;
    localparam int MAX_RES = 4;
    localparam int CNT_W  = $clog2(MAX_RES + 1);

    localparam logic [BYTE_W-1:0] CH_COLON = 8'h3A;
    localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_SP    = 8'h20;

    typedef enum logic [KIND_W-1:0] {
        KIND_PREFIX = 3'd0,
        KIND_CMD    = 3'd1,
        KIND_PARAM  = 3'd2,
        KIND_TRAIL  = 3'd3,
        KIND_END    = 3'd4
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic [IDX_W-1:0]   idx;
        logic [BYTE_W-1:0]  data;
        logic               has_byte;
        logic               close;
        logic               err;
        logic [IDX_W-1:0]   total;
        logic               ovf;
        logic               last;
    } t_rec;

endpackage

/* design/irc_tok_in_if.sv */
interface irc_tok_in_if
    import irc_tok_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;
    logic              last;

    modport source (output valid, output data_byte, output last, input ready);
    modport sink   (input valid, input data_byte, input last, output ready);
endinterface

/* design/irc_tok_out_if.sv */
interface irc_tok_out_if
    import irc_tok_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] field_kind;
    logic [IDX_W-1:0]  param_index;
    logic [BYTE_W-1:0] out_byte;
    logic              has_byte;
    logic              field_close;
    logic              cmd_error;
    logic [IDX_W-1:0]  param_total;
    logic              param_overflow;
    logic              last_result;

    modport source (
        output valid, output field_kind, output param_index, output out_byte,
        output has_byte, output field_close, output cmd_error, output param_total,
        output param_overflow, output last_result, input ready
    );
    modport sink (
        input valid, input field_kind, input param_index, input out_byte,
        input has_byte, input field_close, input cmd_error, input param_total,
        input param_overflow, input last_result, output ready
    );
endinterface

/* design/irc_line_tokenizer_top.sv */
// an accepted item waits in the input register; its results then go to the result buffer
// throughput: one item per cycle while each item gives at most one result and the output
// is not stalled; an item giving more results holds the input register until they drain
// (the four-entry result buffer is refilled only once it empties or its last entry is taken)
// reset: synchronous active low; clears the parser state, held cr and both buffers
module irc_line_tokenizer_top
    import irc_tok_pkg::*;
#(
    parameter int MAX_PARAMS = DEF_MAX_PARAMS
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    irc_tok_in_if.sink    i_in,
    irc_tok_out_if.source o_out
);

    localparam int PCW = $clog2(MAX_PARAMS + 1);
    localparam logic [PCW-1:0] MAXP = PCW'(MAX_PARAMS);

    typedef enum logic [6:0] {
        PH_START   = 7'b0000001,
        PH_PREFIX  = 7'b0000010,
        PH_CMD     = 7'b0000100,
        PH_PSTART  = 7'b0001000,
        PH_PARAM   = 7'b0010000,
        PH_TRAIL   = 7'b0100000,
        PH_DISCARD = 7'b1000000
    } t_phase;

    typedef struct packed {
        t_phase         phase;
        logic           nonempty;
        logic [PCW-1:0] pcnt;
        logic           ovf;
        logic           err;
    } t_st;

    typedef struct packed {
        t_st  st;
        logic v;
        t_rec rec;
    } t_take;

    typedef struct packed {
        t_st  st;
        logic cv;
        t_rec close;
        t_rec endr;
    } t_fin;

    localparam t_st ST_RESET = '{phase: PH_START, nonempty: 1'b0, pcnt: '0,
                                 ovf: 1'b0, err: 1'b0};

    function automatic t_rec mk_rec(t_kind kind, logic [IDX_W-1:0] idx,
                                    logic [BYTE_W-1:0] data, logic hb, logic cl);
        t_rec r;
        r = '0;
        r.kind     = kind;
        r.idx      = idx;
        r.data     = data;
        r.has_byte = hb;
        r.close    = cl;
        return r;
    endfunction

    function automatic t_take take(t_st s, logic [BYTE_W-1:0] b);
        t_take o;
        logic full;
        logic [IDX_W-1:0] idx;
        o.st  = s;
        o.v   = 1'b0;
        o.rec = '0;
        full  = (s.pcnt == MAXP);
        idx   = IDX_W'(s.pcnt);
        if (s.phase == PH_START) begin
            if (b == CH_COLON) begin
                o.st.phase = PH_PREFIX;
            end else begin
                o.st.phase    = PH_CMD;
                o.st.nonempty = 1'b0;
            end
        end
        if (!(s.phase == PH_START && b == CH_COLON)) begin
            unique case (o.st.phase)
                PH_PREFIX: begin
                    o.v = 1'b1;
                    if (b == CH_SP) begin
                        o.rec = mk_rec(KIND_PREFIX, '0, '0, 1'b0, 1'b1);
                        o.st.phase    = PH_CMD;
                        o.st.nonempty = 1'b0;
                    end else begin
                        o.rec = mk_rec(KIND_PREFIX, '0, b, 1'b1, 1'b0);
                    end
                end
                PH_CMD: begin
                    if (b == CH_SP) begin
                        if (o.st.nonempty) begin
                            o.v = 1'b1;
                            o.rec = mk_rec(KIND_CMD, '0, '0, 1'b0, 1'b1);
                            o.st.phase = PH_PSTART;
                        end else begin
                            o.st.err   = 1'b1;
                            o.st.phase = PH_DISCARD;
                        end
                    end else begin
                        o.v = 1'b1;
                        o.rec = mk_rec(KIND_CMD, '0, b, 1'b1, 1'b0);
                        o.st.nonempty = 1'b1;
                    end
                end
                PH_PSTART: begin
                    if (b == CH_COLON) begin
                        o.st.phase = PH_TRAIL;
                    end else if (b == CH_SP) begin
                        if (!full) begin
                            o.v = 1'b1;
                            o.rec = mk_rec(KIND_PARAM, idx, '0, 1'b0, 1'b1);
                            o.st.pcnt = s.pcnt + PCW'(1);
                        end else begin
                            o.st.ovf = 1'b1;
                        end
                    end else begin
                        if (!full) begin
                            o.v = 1'b1;
                            o.rec = mk_rec(KIND_PARAM, idx, b, 1'b1, 1'b0);
                        end else begin
                            o.st.ovf = 1'b1;
                        end
                        o.st.phase = PH_PARAM;
                    end
                end
                PH_PARAM: begin
                    if (b == CH_SP) begin
                        if (!full) begin
                            o.v = 1'b1;
                            o.rec = mk_rec(KIND_PARAM, idx, '0, 1'b0, 1'b1);
                            o.st.pcnt = s.pcnt + PCW'(1);
                        end
                        o.st.phase = PH_PSTART;
                    end else if (!full) begin
                        o.v = 1'b1;
                        o.rec = mk_rec(KIND_PARAM, idx, b, 1'b1, 1'b0);
                    end
                end
                PH_TRAIL: begin
                    o.v = 1'b1;
                    o.rec = mk_rec(KIND_TRAIL, idx, b, 1'b1, 1'b0);
                end
                default: begin
                end
            endcase
        end
        return o;
    endfunction

    function automatic t_fin finish(t_st s);
        t_fin f;
        logic full;
        logic [IDX_W-1:0] idx;
        logic [PCW-1:0] pc;
        logic er;
        full  = (s.pcnt == MAXP);
        idx   = IDX_W'(s.pcnt);
        pc    = s.pcnt;
        er    = s.err;
        f.cv    = 1'b0;
        f.close = '0;
        unique case (s.phase)
            PH_START: er = 1'b1;
            PH_PREFIX: begin
                f.cv = 1'b1;
                f.close = mk_rec(KIND_PREFIX, '0, '0, 1'b0, 1'b1);
                er = 1'b1;
            end
            PH_CMD: begin
                if (s.nonempty) begin
                    f.cv = 1'b1;
                    f.close = mk_rec(KIND_CMD, '0, '0, 1'b0, 1'b1);
                end else begin
                    er = 1'b1;
                end
            end
            PH_PARAM: begin
                if (!full) begin
                    f.cv = 1'b1;
                    f.close = mk_rec(KIND_PARAM, idx, '0, 1'b0, 1'b1);
                    pc = s.pcnt + PCW'(1);
                end
            end
            PH_TRAIL: begin
                f.cv = 1'b1;
                f.close = mk_rec(KIND_TRAIL, idx, '0, 1'b0, 1'b1);
            end
            default: begin
            end
        endcase
        f.endr       = mk_rec(KIND_END, '0, '0, 1'b0, 1'b0);
        f.endr.err   = er;
        f.endr.total = IDX_W'(pc);
        f.endr.ovf   = s.ovf;
        f.st         = ST_RESET;
        return f;
    endfunction

    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_in_last;
    logic              r_held;
    t_st               r_st;
    t_rec              r_buf [MAX_RES];
    logic [CNT_W-1:0]  r_cnt;

    logic              pop;
    logic              process;
    logic              lf_end;
    logic              consume;
    t_take             tk_cr;
    t_take             tk_b;
    t_st               s1;
    t_st               s2;
    t_fin              fin;
    t_rec              cand [MAX_RES];
    logic [MAX_RES-1:0] cand_v;
    t_rec              n_buf [MAX_RES];
    logic [CNT_W-1:0]  n_cnt;
    t_st               n_st;
    logic              n_held;

    assign pop     = o_out.valid && o_out.ready;
    assign process = r_in_valid && ((r_cnt == '0) || ((r_cnt == CNT_W'(1)) && pop));
    assign i_in.ready = !r_in_valid || process;

    always_comb begin
        lf_end  = r_held && (r_in_byte == CH_LF) && r_in_last;
        tk_cr   = take(r_st, CH_CR);
        s1      = (r_held && !lf_end) ? tk_cr.st : r_st;
        consume = !lf_end && !((r_in_byte == CH_CR) && !r_in_last);
        tk_b    = take(s1, r_in_byte);
        s2      = consume ? tk_b.st : s1;
        fin     = finish(s2);

        cand[0]   = tk_cr.rec;
        cand_v[0] = r_held && !lf_end && tk_cr.v;
        cand[1]   = tk_b.rec;
        cand_v[1] = consume && tk_b.v;
        cand[2]   = fin.close;
        cand_v[2] = r_in_last && fin.cv;
        cand[3]   = fin.endr;
        cand_v[3] = r_in_last;

        n_cnt = '0;
        for (int i = 0; i < MAX_RES; i++) begin
            n_buf[i] = '0;
        end
        for (int i = 0; i < MAX_RES; i++) begin
            if (cand_v[i]) begin
                n_buf[n_cnt[CNT_W-2:0]] = cand[i];
                n_cnt = n_cnt + CNT_W'(1);
            end
        end
        if (n_cnt != '0) begin
            n_buf[n_cnt[CNT_W-2:0] - (CNT_W-1)'(1)].last = 1'b1;
        end

        n_st   = r_in_last ? fin.st : s2;
        n_held = (r_in_byte == CH_CR) && !r_in_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.valid && i_in.ready) begin
            r_in_valid <= 1'b1;
        end else if (process) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_byte <= i_in.data_byte;
            r_in_last <= i_in.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= ST_RESET;
            r_held <= 1'b0;
            r_cnt  <= '0;
        end else if (process) begin
            r_st   <= n_st;
            r_held <= n_held;
            r_cnt  <= n_cnt;
        end else if (pop) begin
            r_cnt  <= r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (process) begin
            r_buf <= n_buf;
        end else if (pop) begin
            for (int i = 0; i < MAX_RES - 1; i++) begin
                r_buf[i] <= r_buf[i+1];
            end
        end
    end

    assign o_out.valid          = (r_cnt != '0);
    assign o_out.field_kind     = r_buf[0].kind;
    assign o_out.param_index    = r_buf[0].idx;
    assign o_out.out_byte       = r_buf[0].data;
    assign o_out.has_byte       = r_buf[0].has_byte;
    assign o_out.field_close    = r_buf[0].close;
    assign o_out.cmd_error      = r_buf[0].err;
    assign o_out.param_total    = r_buf[0].total;
    assign o_out.param_overflow = r_buf[0].ovf;
    assign o_out.last_result    = r_buf[0].last;

endmodule

/* design/irc_tok_checker.sv */
module irc_tok_checker
    import irc_tok_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input logic [KIND_W-1:0] i_field_kind,
    input logic [BYTE_W-1:0] i_out_byte,
    input logic              i_has_byte,
    input logic              i_field_close,
    input logic              i_cmd_error,
    input logic [IDX_W-1:0]  i_param_total,
    input logic              i_param_overflow,
    input logic              i_last_result
);

    localparam logic [KIND_W-1:0] K_END = KIND_END;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_field_kind)
            && $stable(i_out_byte))
        else $error("result item dropped or changed while stalled");

    a_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_field_kind == K_END) |-> i_last_result
            && !i_has_byte && !i_field_close)
        else $error("end record malformed");

    a_summary_only_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_field_kind != K_END) |->
            !i_cmd_error && (i_param_total == '0) && !i_param_overflow)
        else $error("summary bits on a field record");

    a_byte_or_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_field_kind != K_END) |-> (i_has_byte != i_field_close))
        else $error("field record must carry exactly one of byte or close");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

endmodule

bind irc_line_tokenizer_top irc_tok_checker u_irc_tok_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_field_kind    (o_out.field_kind),
    .i_out_byte      (o_out.out_byte),
    .i_has_byte      (o_out.has_byte),
    .i_field_close   (o_out.field_close),
    .i_cmd_error     (o_out.cmd_error),
    .i_param_total   (o_out.param_total),
    .i_param_overflow(o_out.param_overflow),
    .i_last_result   (o_out.last_result)
);
